[rtl/core/tstv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tstv_pkg;

  localparam int unsigned CountW = 21;
  localparam int unsigned DigitW = 5;

  localparam logic [CountW-1:0] LimitReset = 21'd1048576;
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};
  localparam logic [DigitW-1:0] LimitDigits = 5'd19;
  localparam logic [DigitW-1:0] DigitSat    = 5'd20;

  localparam logic ActChar = 1'b0;
  localparam logic ActEnd  = 1'b1;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChUpE   = 8'h45;

  typedef enum logic [1:0] {
    SC_BOOL   = 2'd0,
    SC_INT    = 2'd1,
    SC_TEXT   = 2'd2,
    SC_DOUBLE = 2'd3
  } scalar_e;

  // number grammar position, one-hot
  typedef enum logic [9:0] {
    PH_START   = 10'b00_0000_0001,
    PH_SIGN    = 10'b00_0000_0010,
    PH_ZERO    = 10'b00_0000_0100,
    PH_INT     = 10'b00_0000_1000,
    PH_DOT     = 10'b00_0001_0000,
    PH_FRAC    = 10'b00_0010_0000,
    PH_EXP     = 10'b00_0100_0000,
    PH_EXPSIGN = 10'b00_1000_0000,
    PH_EXPDIG  = 10'b01_0000_0000,
    PH_ERR     = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    CMP_EQUAL = 2'd0,
    CMP_BELOW = 2'd1,
    CMP_ABOVE = 2'd2
  } cmp_e;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    phase_e            phase;
    logic              negative;
    logic [DigitW-1:0] digit_count;
    cmp_e              cmp;
    logic [1:0]        word_match;  // bit0 "true", bit1 "false" still possible
  } value_t;

  typedef struct packed {
    logic       adv;
    logic       is_end;
    logic [7:0] char_byte;
  } step_t;

  localparam value_t ValueClear = '{
    byte_count:  '0,
    phase:       PH_START,
    negative:    1'b0,
    digit_count: '0,
    cmp:         CMP_EQUAL,
    word_match:  2'b11
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // decimal digits of 9223372036854775807, most significant first
  function automatic logic [3:0] limit_digit(input logic [DigitW-1:0] idx);
    logic [3:0] d;
    case (idx)
      5'd0:    d = 4'd9;
      5'd1:    d = 4'd2;
      5'd2:    d = 4'd2;
      5'd3:    d = 4'd3;
      5'd4:    d = 4'd3;
      5'd5:    d = 4'd7;
      5'd6:    d = 4'd2;
      5'd7:    d = 4'd0;
      5'd8:    d = 4'd3;
      5'd9:    d = 4'd6;
      5'd10:   d = 4'd8;
      5'd11:   d = 4'd5;
      5'd12:   d = 4'd4;
      5'd13:   d = 4'd7;
      5'd14:   d = 4'd7;
      5'd15:   d = 4'd5;
      5'd16:   d = 4'd8;
      5'd17:   d = 4'd0;
      5'd18:   d = 4'd7;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] true_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h74;  // t
      2'd1:    c = 8'h72;  // r
      2'd2:    c = 8'h75;  // u
      default: c = 8'h65;  // e
    endcase
    return c;
  endfunction

  function automatic logic [7:0] false_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66;  // f
      3'd1:    c = 8'h61;  // a
      3'd2:    c = 8'h6C;  // l
      3'd3:    c = 8'h73;  // s
      3'd4:    c = 8'h65;  // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tstv_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module tstv_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tstv_pkg::step_t step_i,
  output tstv_pkg::value_t     value_o
);
  import tstv_pkg::*;

  value_t val_q, val_d;

  function automatic phase_e next_phase(input phase_e ph, input logic [7:0] c);
    logic   dig;
    logic   ex;
    phase_e np;
    dig = is_digit(c);
    ex  = (c == ChLowE) || (c == ChUpE);
    unique case (ph)
      PH_START, PH_SIGN: begin
        if (ph == PH_START && c == ChMinus) np = PH_SIGN;
        else if (c == ChZero)               np = PH_ZERO;
        else if (dig)                       np = PH_INT;
        else                                np = PH_ERR;
      end
      PH_ZERO, PH_INT: begin
        if (dig && ph == PH_INT) np = PH_INT;
        else if (c == ChDot)     np = PH_DOT;
        else if (ex)             np = PH_EXP;
        else                     np = PH_ERR;
      end
      PH_DOT: begin
        np = dig ? PH_FRAC : PH_ERR;
      end
      PH_FRAC: begin
        if (dig)     np = PH_FRAC;
        else if (ex) np = PH_EXP;
        else         np = PH_ERR;
      end
      PH_EXP, PH_EXPSIGN, PH_EXPDIG: begin
        if (ph == PH_EXP && (c == ChPlus || c == ChMinus)) np = PH_EXPSIGN;
        else if (dig)                                      np = PH_EXPDIG;
        else                                               np = PH_ERR;
      end
      default: begin
        np = PH_ERR;
      end
    endcase
    return np;
  endfunction

  logic [7:0] c;
  phase_e     np;
  logic       neg_d;
  logic [3:0] lim;
  logic [3:0] dval;

  always_comb begin
    c     = step_i.char_byte;
    val_d = val_q;
    np    = next_phase(val_q.phase, c);
    neg_d = val_q.negative || (val_q.byte_count == '0 && c == ChMinus);
    dval  = c[3:0];
    lim   = limit_digit(val_q.digit_count);
    // the last digit of the negative limit is 8
    if (val_q.digit_count == LimitDigits - 5'd1 && neg_d) lim = 4'd8;

    if (step_i.adv) begin
      if (step_i.is_end) begin
        val_d = ValueClear;
      end else begin
        val_d.negative = neg_d;
        val_d.phase    = np;
        if (np == PH_ZERO || np == PH_INT) begin
          if (val_q.digit_count < LimitDigits && val_q.cmp == CMP_EQUAL) begin
            if (dval < lim)      val_d.cmp = CMP_BELOW;
            else if (dval > lim) val_d.cmp = CMP_ABOVE;
          end
          if (val_q.digit_count < DigitSat) val_d.digit_count = val_q.digit_count + 5'd1;
        end
        if (val_q.byte_count >= 21'd4 || true_char(val_q.byte_count[1:0]) != c) begin
          val_d.word_match[0] = 1'b0;
        end
        if (val_q.byte_count >= 21'd5 || false_char(val_q.byte_count[2:0]) != c) begin
          val_d.word_match[1] = 1'b0;
        end
        if (val_q.byte_count != CountMax) val_d.byte_count = val_q.byte_count + 21'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= ValueClear;
    end else begin
      val_q <= val_d;
    end
  end

  assign value_o = val_q;

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.adv && step_i.is_end |=> val_q == ValueClear)
    else $error("value state not cleared after end transaction");

  a_digit_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_q.digit_count <= DigitSat)
    else $error("digit count beyond saturation");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i.adv |=> $stable(val_q))
    else $error("value state changed without a transaction");

endmodule

`default_nettype wire

[rtl/core/tstv_judge.sv]
`timescale 1ns / 1ps
`default_nettype none

module tstv_judge (
  input  wire tstv_pkg::value_t  value_i,
  input  wire tstv_pkg::scalar_e scalar_type_i,
  input  wire logic [20:0]       limit_i,
  output logic                   is_valid_o
);
  import tstv_pkg::*;

  logic int_phase;

  always_comb begin
    int_phase = (value_i.phase == PH_ZERO) || (value_i.phase == PH_INT);
    unique case (scalar_type_i)
      SC_BOOL: begin
        is_valid_o = (value_i.word_match[0] && value_i.byte_count == 21'd4) ||
                     (value_i.word_match[1] && value_i.byte_count == 21'd5);
      end
      SC_INT: begin
        is_valid_o = int_phase &&
                     ((value_i.digit_count < LimitDigits) ||
                      (value_i.digit_count == LimitDigits && value_i.cmp != CMP_ABOVE));
      end
      SC_TEXT: begin
        is_valid_o = value_i.byte_count <= limit_i;
      end
      SC_DOUBLE: begin
        is_valid_o = int_phase || (value_i.phase == PH_FRAC) ||
                     (value_i.phase == PH_EXPDIG);
      end
      default: begin
        is_valid_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/typed_scalar_text_validator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    action_i, char_byte_i, scalar_type_i
// out      output     out_valid_o / out_ready_i  is_valid_o
// cfg      input      cfg_we_i                   cfg_wdata_i (text length limit)
//
// One transaction per cycle unless an end item stalls: an item is registered, then
// updates the value state, or for an end item is judged into the result register.
// Character items never wait on the output; an end item waits only while the
// result register is full and not taken.
// Reset clears the value state and sets the text length limit to 1048576.

module typed_scalar_text_validator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic [1:0]  scalar_type_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             is_valid_o,
  input  wire logic        cfg_we_i,
  input  wire logic [20:0] cfg_wdata_i
);
  import tstv_pkg::*;

  logic              in_vld_q, in_vld_d;
  logic              in_end_q;
  logic [7:0]        in_char_q;
  scalar_e           in_type_q;
  logic              out_vld_q, out_vld_d;
  logic              res_q;
  logic [CountW-1:0] limit_q;
  logic              adv;
  logic              judge_valid;
  step_t             step;
  value_t            value;

  assign adv        = in_vld_q && (!in_end_q || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv && in_end_q) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  assign step = '{adv: adv, is_end: in_end_q, char_byte: in_char_q};

  tstv_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .value_o (value)
  );

  tstv_judge u_judge (
    .value_i       (value),
    .scalar_type_i (in_type_q),
    .limit_i       (limit_q),
    .is_valid_o    (judge_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      limit_q   <= LimitReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_end_q  <= (action_i == ActEnd);
      in_char_q <= char_byte_i;
      in_type_q <= scalar_e'(scalar_type_i);
    end
    if (adv && in_end_q) res_q <= judge_valid;
  end

  assign out_valid_o = out_vld_q;
  assign is_valid_o  = res_q;

  a_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_end_q |=> out_vld_q == $past(out_vld_q && !out_ready_i))
    else $error("character transaction changed the result register");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_end_q |=> out_vld_q)
    else $error("end transaction produced no result");

  a_pending_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_end_q) && $stable(in_char_q))
    else $error("pending item lost while stalled");

endmodule

`default_nettype wire

[dv/typed_scalar_text_validator_tb.sv]
`timescale 1ns / 1ps

module typed_scalar_text_validator_tb;
  import tstv_pkg::*;

  localparam int RandomItems = 1600;
  localparam int CfgEvery    = 300;
  localparam int NoCheck     = -1;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [7:0]  char_byte;
  logic [1:0]  scalar_type;
  logic        out_valid;
  logic        out_ready;
  logic        is_valid;
  logic        cfg_we;
  logic [20:0] cfg_wdata;

  typed_scalar_text_validator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .char_byte_i   (char_byte),
    .scalar_type_i (scalar_type),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .is_valid_o    (is_valid),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  // value state mirror
  logic [CountW-1:0] len_limit;
  logic [CountW-1:0] vc_count;
  phase_e            vc_phase;
  logic              vc_neg;
  logic [DigitW-1:0] vc_digits;
  cmp_e              vc_cmp;
  logic [1:0]        vc_words;

  string int64_max  = "9223372036854775807";
  string true_word  = "true";
  string false_word = "false";

  logic pending_validity[$];
  logic verdict;
  int   item_note;
  int   mismatches;
  int   n_accepted;
  int   n_results;
  int   n_true;
  int   stim_items;
  bit   in_calm;
  bit   out_calm;
  int   stall_left;

  logic [7:0] value_bytes[$];
  string      row_text[$];
  scalar_e    row_type[$];
  int         row_want[$];

  function automatic phase_e grammar_step(phase_e ph, logic [7:0] c);
    logic   dig;
    logic   ex;
    phase_e np;
    dig = (c >= ChZero) && (c <= ChNine);
    ex  = (c == ChLowE) || (c == ChUpE);
    np  = PH_ERR;
    case (ph)
      PH_START, PH_SIGN: begin
        if (ph == PH_START && c == ChMinus) np = PH_SIGN;
        else if (c == ChZero) np = PH_ZERO;
        else if (dig) np = PH_INT;
      end
      PH_ZERO, PH_INT: begin
        if (dig && ph == PH_INT) np = PH_INT;
        else if (c == ChDot) np = PH_DOT;
        else if (ex) np = PH_EXP;
      end
      PH_DOT: if (dig) np = PH_FRAC;
      PH_FRAC: begin
        if (dig) np = PH_FRAC;
        else if (ex) np = PH_EXP;
      end
      PH_EXP: begin
        if (c == ChPlus || c == ChMinus) np = PH_EXPSIGN;
        else if (dig) np = PH_EXPDIG;
      end
      PH_EXPSIGN, PH_EXPDIG: if (dig) np = PH_EXPDIG;
      default: np = PH_ERR;
    endcase
    return np;
  endfunction

  task automatic clear_value();
    vc_count  = '0;
    vc_phase  = PH_START;
    vc_neg    = 1'b0;
    vc_digits = '0;
    vc_cmp    = CMP_EQUAL;
    vc_words  = 2'b11;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    phase_e np;
    int     lim;
    int     d;
    np = grammar_step(vc_phase, c);
    if (vc_count == 0 && c == ChMinus) vc_neg = 1'b1;
    if (np == PH_ZERO || np == PH_INT) begin
      if (vc_digits < LimitDigits && vc_cmp == CMP_EQUAL) begin
        lim = int'(int64_max[vc_digits]) - int'(ChZero);
        if (vc_digits == LimitDigits - 1 && vc_neg) lim = 8;
        d = int'(c) - int'(ChZero);
        if (d < lim) vc_cmp = CMP_BELOW;
        else if (d > lim) vc_cmp = CMP_ABOVE;
      end
      if (vc_digits < DigitSat) vc_digits = vc_digits + 1'b1;
    end
    vc_phase = np;
    if (vc_count >= 4) vc_words[0] = 1'b0;
    else if (true_word[vc_count[1:0]] != c) vc_words[0] = 1'b0;
    if (vc_count >= 5) vc_words[1] = 1'b0;
    else if (false_word[vc_count[2:0]] != c) vc_words[1] = 1'b0;
    if (vc_count != CountMax) vc_count = vc_count + 1'b1;
  endtask

  function automatic logic judge_value(scalar_e ty);
    logic ok;
    case (ty)
      SC_BOOL:
        ok = (vc_words[0] && vc_count == 4) || (vc_words[1] && vc_count == 5);
      SC_INT: begin
        if (vc_phase != PH_ZERO && vc_phase != PH_INT) ok = 1'b0;
        else if (vc_digits < LimitDigits) ok = 1'b1;
        else ok = (vc_digits == LimitDigits) && (vc_cmp != CMP_ABOVE);
      end
      SC_TEXT: ok = (vc_count <= len_limit);
      default:
        ok = (vc_phase == PH_ZERO) || (vc_phase == PH_INT) ||
             (vc_phase == PH_FRAC) || (vc_phase == PH_EXPDIG);
    endcase
    return ok;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("typed_scalar_text_validator_tb: done, errors");
    $finish;
  end

  // prediction on accepted inputs, checking on accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) len_limit = cfg_wdata;
      if (in_valid && in_ready) begin
        n_accepted++;
        if (action == ActChar) begin
          absorb_char(char_byte);
        end else begin
          verdict = judge_value(scalar_e'(scalar_type));
          if (item_note != NoCheck) verdict = item_note[0];
          pending_validity.push_back(verdict);
          clear_value();
        end
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (is_valid === 1'b1) n_true++;
        if (pending_validity.size() == 0) begin
          $error("is_valid: expected nothing, got %0d", is_valid);
          mismatches++;
        end else begin
          verdict = pending_validity.pop_front();
          if (is_valid !== verdict) begin
            $error("is_valid: expected %0d, got %0d", verdict, is_valid);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // result side backpressure
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    out_calm   = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len(out_calm);
      end
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic drive_item(input logic act, input logic [7:0] b, input logic [1:0] ty,
                            input int note);
    int gap;
    gap = idle_len(in_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    = 1'b1;
    action      = act;
    char_byte   = b;
    scalar_type = ty;
    item_note   = note;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_value(input scalar_e end_ty, input int want);
    int i;
    for (i = 0; i < value_bytes.size(); i++)
      drive_item(ActChar, value_bytes[i], 2'($urandom_range(0, 3)), NoCheck);
    drive_item(ActEnd, 8'($urandom_range(0, 255)), end_ty, want);
    stim_items += value_bytes.size() + 1;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_validity.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [20:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic add_row(input string s, input scalar_e ty, input int want);
    row_text.push_back(s);
    row_type.push_back(ty);
    row_want.push_back(want);
  endtask

  task automatic walk_rows();
    int r;
    int i;
    for (r = 0; r < row_text.size(); r++) begin
      value_bytes.delete();
      for (i = 0; i < row_text[r].len(); i++) value_bytes.push_back(row_text[r][i]);
      send_value(row_type[r], row_want[r]);
    end
    row_text.delete();
    row_type.delete();
    row_want.delete();
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return ChMinus;
      1:       return ChPlus;
      2:       return ChDot;
      3:       return ChLowE;
      4:       return ChUpE;
      5:       return ChZero;
      6:       return ChZero + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_digits(input int n, input bit lead_nonzero);
    int i;
    for (i = 0; i < n; i++) begin
      if (i == 0 && lead_nonzero) value_bytes.push_back(ChZero + 8'($urandom_range(1, 9)));
      else value_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
    end
  endtask

  // mostly well-formed values of a random kind, some damaged afterwards
  task automatic build_value(output scalar_e kind);
    int         r;
    int         len;
    int         k;
    int         i;
    int         pos;
    bit         neg;
    string      w;
    logic [7:0] d;
    value_bytes.delete();
    kind = scalar_e'($urandom_range(0, 3));
    case (kind)
      SC_BOOL: begin
        w = $urandom_range(0, 1) ? "true" : "false";
        for (i = 0; i < w.len(); i++) value_bytes.push_back(w[i]);
        r = $urandom_range(0, 5);
        if (r == 0) void'(value_bytes.pop_back());
        else if (r == 1) value_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
        else if (r == 2) begin
          pos = $urandom_range(0, value_bytes.size() - 1);
          value_bytes[pos] = value_bytes[pos] ^ 8'h20;
        end
      end
      SC_INT: begin
        neg = $urandom_range(0, 1);
        if (neg) value_bytes.push_back(ChMinus);
        r = $urandom_range(0, 9);
        if (r == 0) begin
          value_bytes.push_back(ChZero);
        end else if (r < 5) begin
          push_digits($urandom_range(1, 8), 1'b1);
        end else begin
          // follow the limit digits for a while, then diverge
          len = $urandom_range(18, 20);
          k   = $urandom_range(0, len);
          for (i = 0; i < len; i++) begin
            if (i < k && i < 19) d = (neg && i == 18) ? 8'h38 : 8'(int64_max[i]);
            else if (i == 0) d = ChZero + 8'($urandom_range(1, 9));
            else d = ChZero + 8'($urandom_range(0, 9));
            value_bytes.push_back(d);
          end
        end
      end
      SC_TEXT: begin
        len = $urandom_range(0, 50);
        for (i = 0; i < len; i++) value_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        if ($urandom_range(0, 2) == 0) value_bytes.push_back(ChMinus);
        if ($urandom_range(0, 3) == 0) value_bytes.push_back(ChZero);
        else push_digits($urandom_range(1, 5), 1'b1);
        if ($urandom_range(0, 9) < 6) begin
          value_bytes.push_back(ChDot);
          push_digits($urandom_range(1, 4), 1'b0);
        end
        if ($urandom_range(0, 1)) begin
          value_bytes.push_back($urandom_range(0, 1) ? ChLowE : ChUpE);
          r = $urandom_range(0, 2);
          if (r == 1) value_bytes.push_back(ChPlus);
          else if (r == 2) value_bytes.push_back(ChMinus);
          push_digits($urandom_range(1, 3), 1'b0);
        end
      end
    endcase
    r = $urandom_range(0, 99);
    if (value_bytes.size() > 0) begin
      pos = $urandom_range(0, value_bytes.size() - 1);
      if (r < 12) value_bytes[pos] = noise_byte();
      else if (r < 17) value_bytes.delete(pos);
      else if (r < 22) value_bytes.insert(pos, noise_byte());
    end
  endtask

  initial begin
    scalar_e kind;
    scalar_e end_ty;
    int      next_cfg;
    int      phase_idx;

    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    action      = ActChar;
    char_byte   = '0;
    scalar_type = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    item_note   = NoCheck;
    in_calm     = 1'b0;
    mismatches  = 0;
    n_accepted  = 0;
    n_results   = 0;
    n_true      = 0;
    stim_items  = 0;
    len_limit   = LimitReset;
    clear_value();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed values under the reset limit
    add_row("", SC_BOOL, 0);
    add_row("", SC_TEXT, 1);
    add_row("", SC_INT, 0);
    add_row("", SC_DOUBLE, 0);
    add_row("true", SC_BOOL, 1);
    add_row("false", SC_BOOL, 1);
    add_row("True", SC_BOOL, 0);
    add_row("truee", SC_BOOL, 0);
    add_row("0", SC_INT, 1);
    add_row("-0", SC_INT, 1);
    add_row("01", SC_INT, 0);
    add_row("+1", SC_INT, 0);
    add_row("1e5", SC_INT, 0);
    add_row("9223372036854775807", SC_INT, 1);
    add_row("9223372036854775808", SC_INT, 0);
    add_row("-9223372036854775808", SC_INT, 1);
    add_row("-9223372036854775809", SC_INT, 0);
    add_row("10000000000000000000", SC_INT, 0);
    add_row("-1.5e+10", SC_DOUBLE, 1);
    add_row("1.", SC_DOUBLE, 0);
    add_row(".5", SC_DOUBLE, 0);
    add_row("2E-", SC_DOUBLE, 0);
    add_row("0.0E9", SC_DOUBLE, NoCheck);
    add_row("12ab", SC_TEXT, NoCheck);
    walk_rows();

    // text limit edges
    settle();
    write_limit('0);
    add_row("", SC_TEXT, 1);
    add_row("a", SC_TEXT, 0);
    walk_rows();
    settle();
    write_limit(21'd5);
    add_row("abcde", SC_TEXT, 1);
    add_row("abcdef", SC_TEXT, 0);
    walk_rows();

    stim_items = 0;
    next_cfg   = 0;
    phase_idx  = 0;
    while (stim_items < RandomItems) begin
      if (stim_items >= next_cfg) begin
        settle();
        case (phase_idx % 5)
          0:       write_limit(21'($urandom_range(0, 48)));
          1:       write_limit('0);
          2:       write_limit(CountMax);
          3:       write_limit(LimitReset);
          default: write_limit(21'($urandom_range(1, 12)));
        endcase
        phase_idx++;
        next_cfg += CfgEvery;
      end
      build_value(kind);
      end_ty = ($urandom_range(0, 3) == 0) ? scalar_e'($urandom_range(0, 3)) : kind;
      send_value(end_ty, NoCheck);
      if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    end
    settle();

    $display("Checked %0d input transactions and %0d results (%0d valid) over all four types,",
             n_accepted, n_results, n_true);
    $display("with text limits of 0, small values, the reset value and all ones.");
    if (mismatches == 0) begin
      $display("typed_scalar_text_validator_tb: done, clean");
    end else begin
      $display("typed_scalar_text_validator_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tstv_pkg.sv
rtl/core/tstv_scan.sv
rtl/core/tstv_judge.sv
rtl/core/typed_scalar_text_validator.sv
dv/typed_scalar_text_validator_tb.sv
